// ===== design/bisection_root_finder_assert.svh =====
// Assertion macros for the bisection root finder.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BISECTION_ROOT_FINDER_ASSERT_SVH
`define BISECTION_ROOT_FINDER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define BISR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BISR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/bisr_pkg.sv =====
// Shared types and constants for the bisection root finder.
// Used by bisr_poly_eval and bisection_root_finder; no dependencies.
package bisr_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int ACC_W         = VALUE_WIDTH + 16;
	localparam int SPLIT_W       = ACC_W / 2;
	localparam int PROD_W        = SPLIT_W + VALUE_WIDTH;
	localparam int SUM_W         = PROD_W + SPLIT_W - FRACTION_BITS;
	localparam int HORNER_STEPS  = 3;
	localparam int STEP_W        = $clog2(HORNER_STEPS);
	localparam int EPS_W         = 31;
	localparam int ITER_W        = 6;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic [ITER_W-1:0] ITER_MAX   = ITER_W'(32);
	localparam logic [ITER_W-1:0] ITER_LIMIT = ITER_W'(63);
	localparam logic [EPS_W-1:0]  EPS_MIN    = EPS_W'(2);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic signed [VALUE_WIDTH-1:0] COEF_CUBIC_RST    = 32'sd0;
	localparam logic signed [VALUE_WIDTH-1:0] COEF_SQUARE_RST   = 32'sd65536;
	localparam logic signed [VALUE_WIDTH-1:0] COEF_LINEAR_RST   = -32'sd196608;
	localparam logic signed [VALUE_WIDTH-1:0] COEF_CONSTANT_RST = -32'sd655360;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_CUBIC    = 3'd0,
		REG_COEF_SQUARE   = 3'd1,
		REG_COEF_LINEAR   = 3'd2,
		REG_COEF_CONSTANT = 3'd3,
		REG_EPSILON       = 3'd4
	} bisr_reg_t;

	typedef enum logic [2:0] {
		EV_IDLE,
		EV_MAG,
		EV_MUL_LO,
		EV_MUL_HI,
		EV_COMBINE,
		EV_ADD
	} bisr_ev_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL_LO,
		ST_EVAL_HI,
		ST_CHECK,
		ST_EVAL_MID,
		ST_FINISH
	} bisr_state_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] lower;
		logic signed [VALUE_WIDTH-1:0] upper;
	} bisr_in_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] root;
		logic [ITER_W-1:0]             iterations;
		logic                          status;
	} bisr_out_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] cubic;
		logic signed [VALUE_WIDTH-1:0] square;
		logic signed [VALUE_WIDTH-1:0] linear;
		logic signed [VALUE_WIDTH-1:0] constant;
	} bisr_coef_t;

	typedef struct packed {
		logic                          start;
		logic signed [VALUE_WIDTH-1:0] x;
	} bisr_eval_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic neg;
		logic zero;
	} bisr_eval_rsp_t;

endpackage

// ===== design/bisr_poly_eval.sv =====
// Horner evaluator for the cubic: sign and zero test of p(x).
// One 24x32 multiplier shared over partial products. Depends on bisr_pkg.
module bisr_poly_eval import bisr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  bisr_eval_req_t req,
	input  bisr_coef_t     coef,
	output bisr_eval_rsp_t rsp
);

	localparam logic [SUM_W-1:0] MAG_LIM = SUM_W'(1) << (ACC_W - 1);

	bisr_ev_state_t state_q, state_nxt;
	logic [STEP_W-1:0]              step_q;
	logic                           done_q;
	logic signed [VALUE_WIDTH-1:0]  x_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic [ACC_W-1:0]               am_q;
	logic [VALUE_WIDTH-1:0]         xm_q;
	logic                           neg_q;
	logic [PROD_W-1:0]              pl_q;
	logic [PROD_W-1:0]              ph_q;
	logic [ACC_W-1:0]               rm_q;

	logic [ACC_W-1:0]               am;
	logic [VALUE_WIDTH-1:0]         xm;
	logic [SPLIT_W-1:0]             mul_a;
	logic [PROD_W-1:0]              mul_p;
	logic [SUM_W-1:0]               sum_r;
	logic [ACC_W-1:0]               rm;
	logic signed [VALUE_WIDTH-1:0]  coef_sel;
	logic signed [ACC_W+1:0]        coef_ext;
	logic signed [ACC_W+1:0]        rm_ext;
	logic signed [ACC_W+1:0]        sum_s;
	logic signed [ACC_W-1:0]        acc_nxt;
	logic                           last_step;

	assign last_step = (step_q == STEP_W'(HORNER_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == EV_ADD) && last_step;
			if (state_q == EV_IDLE && req.start) begin
				step_q <= '0;
			end else if (state_q == EV_ADD) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			EV_IDLE:    if (req.start) state_nxt = EV_MAG;
			EV_MAG:     state_nxt = EV_MUL_LO;
			EV_MUL_LO:  state_nxt = EV_MUL_HI;
			EV_MUL_HI:  state_nxt = EV_COMBINE;
			EV_COMBINE: state_nxt = EV_ADD;
			EV_ADD:     state_nxt = last_step ? EV_IDLE : EV_MAG;
			default:    state_nxt = EV_IDLE;
		endcase
		rsp.busy = (state_q != EV_IDLE);
		rsp.done = done_q;
		rsp.neg  = acc_q[ACC_W-1];
		rsp.zero = (acc_q == '0);
	end

	// Magnitudes: the product truncates toward zero, so work on |acc| and |x|.
	assign am = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign xm = x_q[VALUE_WIDTH-1] ? (~x_q + 1'b1) : x_q;

	assign mul_a = (state_q == EV_MUL_HI) ? am_q[ACC_W-1:SPLIT_W] : am_q[SPLIT_W-1:0];
	assign mul_p = PROD_W'(mul_a) * PROD_W'(xm_q);

	always_comb begin
		sum_r = (SUM_W'(ph_q) << (SPLIT_W - FRACTION_BITS)) + SUM_W'(pl_q >> FRACTION_BITS);
		if (sum_r >= MAG_LIM) begin
			rm = neg_q ? ACC_W'(MAG_LIM) : ACC_W'(MAG_LIM - 1'b1);
		end else begin
			rm = sum_r[ACC_W-1:0];
		end
	end

	always_comb begin
		case (step_q)
			STEP_W'(0): coef_sel = coef.square;
			STEP_W'(1): coef_sel = coef.linear;
			default:    coef_sel = coef.constant;
		endcase
		coef_ext = (ACC_W+2)'(coef_sel);
		rm_ext   = {2'b00, rm_q};
		sum_s    = neg_q ? (coef_ext - rm_ext) : (coef_ext + rm_ext);
		if (sum_s[ACC_W+1] == sum_s[ACC_W] && sum_s[ACC_W] == sum_s[ACC_W-1]) begin
			acc_nxt = sum_s[ACC_W-1:0];
		end else begin
			acc_nxt = sum_s[ACC_W+1] ? ACC_MIN : ACC_MAX;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			EV_IDLE: begin
				if (req.start) begin
					acc_q <= ACC_W'(coef.cubic);
					x_q   <= req.x;
				end
			end
			EV_MAG: begin
				am_q  <= am;
				xm_q  <= xm;
				neg_q <= acc_q[ACC_W-1] ^ x_q[VALUE_WIDTH-1];
			end
			EV_MUL_LO:  pl_q  <= mul_p;
			EV_MUL_HI:  ph_q  <= mul_p;
			EV_COMBINE: rm_q  <= rm;
			EV_ADD:     acc_q <= acc_nxt;
			default: ;
		endcase
	end

endmodule

// ===== design/bisection_root_finder.sv =====
// Bisection root finder for a configurable cubic in signed Q16.16. An item is a search
// interval; the result is the last midpoint, the number of halvings and a status (1 when
// the polynomial shows no strict sign change across the interval). One item is in work at
// a time. Each polynomial evaluation is three Horner steps, each through the states
// EV_MAG, EV_MUL_LO, EV_MUL_HI, EV_COMBINE and EV_ADD on one shared 24x32 multiplier.
// An item takes at most 32 halvings. A finished result waits in an output register, and
// the next interval is taken while it waits.
`include "bisection_root_finder_assert.svh"

module bisection_root_finder import bisr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  bisr_in_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output bisr_out_t              out_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	bisr_state_t state_q, state_nxt;
	bisr_coef_t                    coef_q;
	logic [EPS_W-1:0]              eps_q;
	logic signed [VALUE_WIDTH-1:0] a_q;
	logic signed [VALUE_WIDTH-1:0] b_q;
	logic signed [VALUE_WIDTH-1:0] c_q;
	logic [ITER_W-1:0]             iter_q;
	logic                          sa_neg_q;
	logic                          sa_zero_q;
	logic                          status_q;
	logic                          out_valid_q;
	bisr_out_t                     out_q;

	bisr_eval_req_t                eval_req;
	bisr_eval_rsp_t                eval_rsp;

	logic                          accept;
	logic                          load_out;
	logic                          go_halve;
	logic                          no_bracket;
	logic [EPS_W-1:0]              eps_eff;
	logic signed [VALUE_WIDTH:0]   diff;
	logic signed [VALUE_WIDTH:0]   mid_sum;
	logic signed [VALUE_WIDTH-1:0] mid;
	logic                          wide_enough;

	bisr_poly_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (eval_req),
		.coef   (coef_q),
		.rsp    (eval_rsp)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.cubic    <= COEF_CUBIC_RST;
			coef_q.square   <= COEF_SQUARE_RST;
			coef_q.linear   <= COEF_LINEAR_RST;
			coef_q.constant <= COEF_CONSTANT_RST;
			eps_q           <= EPS_MIN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COEF_CUBIC:    coef_q.cubic    <= cfg_data;
				REG_COEF_SQUARE:   coef_q.square   <= cfg_data;
				REG_COEF_LINEAR:   coef_q.linear   <= cfg_data;
				REG_COEF_CONSTANT: coef_q.constant <= cfg_data;
				REG_EPSILON:       eps_q           <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	assign eps_eff     = (eps_q < EPS_MIN) ? EPS_MIN : eps_q;
	assign diff        = (VALUE_WIDTH+1)'(b_q) - (VALUE_WIDTH+1)'(a_q);
	assign wide_enough = !diff[VALUE_WIDTH] && (diff[VALUE_WIDTH-1:0] >= VALUE_WIDTH'(eps_eff));
	assign go_halve    = wide_enough && (iter_q != ITER_LIMIT);
	// Floor of the average: arithmetic shift of the one-bit-wider sum
	assign mid_sum     = (VALUE_WIDTH+1)'(a_q) + (VALUE_WIDTH+1)'(b_q);
	assign mid         = mid_sum[VALUE_WIDTH:1];
	assign no_bracket  = sa_zero_q || eval_rsp.zero || (sa_neg_q == eval_rsp.neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt      = state_q;
		eval_req.start = 1'b0;
		eval_req.x     = mid;
		unique case (state_q)
			ST_IDLE: begin
				eval_req.x = in_data.lower;
				if (in_valid) begin
					eval_req.start = 1'b1;
					state_nxt      = ST_EVAL_LO;
				end
			end
			ST_EVAL_LO: begin
				eval_req.x = b_q;
				if (eval_rsp.done) begin
					eval_req.start = 1'b1;
					state_nxt      = ST_EVAL_HI;
				end
			end
			ST_EVAL_HI: begin
				if (eval_rsp.done) state_nxt = no_bracket ? ST_FINISH : ST_CHECK;
			end
			ST_CHECK: begin
				if (go_halve) begin
					eval_req.start = 1'b1;
					state_nxt      = ST_EVAL_MID;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_EVAL_MID: begin
				if (eval_rsp.done) state_nxt = eval_rsp.zero ? ST_FINISH : ST_CHECK;
			end
			ST_FINISH: begin
				if (load_out) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Interval, midpoint and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q   <= '0;
			status_q <= 1'b0;
		end else begin
			if (accept) begin
				iter_q   <= '0;
				status_q <= 1'b0;
			end else if (state_q == ST_EVAL_HI && eval_rsp.done && no_bracket) begin
				status_q <= 1'b1;
			end else if (state_q == ST_EVAL_MID && eval_rsp.done && !eval_rsp.zero) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= in_data.lower;
			b_q <= in_data.upper;
			c_q <= in_data.lower;
		end else if (state_q == ST_EVAL_LO && eval_rsp.done) begin
			sa_neg_q  <= eval_rsp.neg;
			sa_zero_q <= eval_rsp.zero;
		end else if (state_q == ST_CHECK && go_halve) begin
			c_q <= mid;
		end else if (state_q == ST_EVAL_MID && eval_rsp.done && !eval_rsp.zero) begin
			// keep the half whose ends still differ in sign
			if (eval_rsp.neg != sa_neg_q) begin
				b_q <= c_q;
			end else begin
				a_q <= c_q;
			end
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.root       <= status_q ? '0 : c_q;
			out_q.iterations <= status_q ? '0 : iter_q;
			out_q.status     <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BISR_ASSERT_IMPLY(a_done_in_eval, eval_rsp.done, state_q == ST_EVAL_LO || state_q == ST_EVAL_HI || state_q == ST_EVAL_MID, "evaluator finished outside an evaluation state")
	`BISR_ASSERT_IMPLY(a_start_idle, eval_req.start, !eval_rsp.busy, "evaluator started while busy")
	`BISR_ASSERT_ALWAYS(a_iter_bound, iter_q <= ITER_MAX, "halving count beyond bound")
	`BISR_ASSERT_IMPLY(a_no_bracket_out, out_valid && out_data.status, out_data.root == '0 && out_data.iterations == '0, "no-bracket result with nonzero root or count")
	`BISR_ASSERT_IMPLY(a_check_bracket, state_q == ST_CHECK, !status_q, "halving without a valid bracket")

endmodule
